// ----- hw/rtl/otb_pkg.sv -----
// Shared types and constants for the overwriting event trace buffer.
`default_nettype none

package otb_pkg;

    // Fixed field widths of one event and of the header counts
    localparam int TIME_W  = 16;
    localparam int SRC_W   = 4;
    localparam int CODE_W  = 8;
    localparam int ARG_W   = 16;
    localparam int COUNT_W = 6;
    localparam int DROP_W  = 32;

    // Command codes on the input channel
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    // Result kinds on the output channel
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One stored trace entry
    typedef struct packed {
        logic [TIME_W-1:0]        time_ms;
        logic [SRC_W-1:0]         source;
        logic [CODE_W-1:0]        code;
        logic signed [ARG_W-1:0]  a;
        logic signed [ARG_W-1:0]  b;
    } entry_t;

    // One classified command waiting for the back end
    typedef struct packed {
        logic   is_dump;
        entry_t ev;
    } item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/otb_front.sv -----
// Front end: accepts command beats, drops records with a bad source, queues the rest.
`default_nettype none

module otb_front #(
    parameter int SOURCE_COUNT = 6
) (
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        command,
    input  wire logic [otb_pkg::TIME_W-1:0]  time_ms,
    input  wire logic [otb_pkg::SRC_W-1:0]   source,
    input  wire logic [otb_pkg::CODE_W-1:0]  event_code,
    input  wire logic signed [otb_pkg::ARG_W-1:0] value_a,
    input  wire logic signed [otb_pkg::ARG_W-1:0] value_b,
    input  wire logic                        q_full,
    output logic                             q_push,
    output otb_pkg::item_t                   q_item
);
    import otb_pkg::*;

    logic src_ok;
    logic is_dump;

    // Classify the beat
    assign is_dump = (command == CMD_DUMP);
    assign src_ok  = ({1'b0, source} < (SRC_W + 1)'(SOURCE_COUNT));

    // Hold the input while the queue is full
    assign in_stall = q_full;

    // Push dumps and valid records, drop the rest
    assign q_push = in_valid && !q_full && (is_dump || src_ok);

    always_comb
    begin
        q_item.is_dump    = is_dump;
        q_item.ev.time_ms = time_ms;
        q_item.ev.source  = source;
        q_item.ev.code    = event_code;
        q_item.ev.a       = value_a;
        q_item.ev.b       = value_b;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/otb_queue.sv -----
// Short FIFO that decouples the front end from the back end.
`default_nettype none

module otb_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire otb_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output otb_pkg::item_t      head_item,
    output logic                empty
);
    import otb_pkg::*;

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/otb_back.sv -----
// Back end: ring memory, head/fill/dropped counters, dump sequencer and output register.
`default_nettype none

module otb_back #(
    parameter int DEPTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire otb_pkg::item_t               q_item,
    input  wire logic                         q_empty,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              kind,
    output logic [otb_pkg::COUNT_W-1:0]       entry_count,
    output logic [otb_pkg::DROP_W-1:0]        dropped_count,
    output logic [otb_pkg::TIME_W-1:0]        out_time_ms,
    output logic [otb_pkg::SRC_W-1:0]         out_source,
    output logic [otb_pkg::CODE_W-1:0]        out_code,
    output logic signed [otb_pkg::ARG_W-1:0]  out_a,
    output logic signed [otb_pkg::ARG_W-1:0]  out_b,
    output logic                              last
);
    import otb_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // Ring storage
    entry_t mem [DEPTH];
    entry_t rdata_reg;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [DROP_W-1:0]  dropped_reg, dropped_next;
    logic [IDX_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic               out_valid_reg, out_valid_next;

    logic               kind_reg, kind_next;
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic [DROP_W-1:0]  dropped_count_reg, dropped_count_next;
    entry_t             out_ev_reg, out_ev_next;
    logic               last_reg, last_next;

    logic               wr_en;
    logic               rd_en;
    logic               out_free;
    logic [CNT_W:0]     oldest_sum;
    logic [IDX_W-1:0]   oldest;

    assign out_free = !out_valid_reg || !out_stall;

    // Oldest slot: head minus fill, modulo the depth
    assign oldest_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(DEPTH) - (CNT_W + 1)'(fill_reg);
    assign oldest     = (oldest_sum >= (CNT_W + 1)'(DEPTH))
                        ? IDX_W'(oldest_sum - (CNT_W + 1)'(DEPTH))
                        : IDX_W'(oldest_sum);

    // Sequence records and dumps
    always_comb
    begin
        state_next         = state_reg;
        head_next          = head_reg;
        fill_next          = fill_reg;
        dropped_next       = dropped_reg;
        rd_ptr_next        = rd_ptr_reg;
        remain_next        = remain_reg;
        out_valid_next     = out_valid_reg && out_stall;
        kind_next          = kind_reg;
        entry_count_next   = entry_count_reg;
        dropped_count_next = dropped_count_reg;
        out_ev_next        = out_ev_reg;
        last_next          = last_reg;
        q_pop              = 1'b0;
        wr_en              = 1'b0;
        rd_en              = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && !q_item.is_dump)
                begin
                    // Record: write at head, advance, count or drop
                    q_pop     = 1'b1;
                    wr_en     = 1'b1;
                    head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    if (fill_reg != CNT_W'(DEPTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    else if (dropped_reg != '1)
                    begin
                        dropped_next = dropped_reg + 1'b1;
                    end
                end
                else if (!q_empty && out_free)
                begin
                    // Dump: emit header, latch walk, clear counters
                    q_pop              = 1'b1;
                    out_valid_next     = 1'b1;
                    kind_next          = KIND_HEADER;
                    entry_count_next   = COUNT_W'(fill_reg);
                    dropped_count_next = dropped_reg;
                    out_ev_next        = '0;
                    last_next          = (fill_reg == '0);
                    rd_ptr_next        = oldest;
                    remain_next        = fill_reg;
                    head_next          = '0;
                    fill_next          = '0;
                    dropped_next       = '0;
                    if (fill_reg != '0)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    // Emit one stored entry, oldest first
                    out_valid_next     = 1'b1;
                    kind_next          = KIND_ENTRY;
                    entry_count_next   = '0;
                    dropped_count_next = '0;
                    out_ev_next        = rdata_reg;
                    last_next          = (remain_reg == CNT_W'(1));
                    rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                    remain_next = remain_reg - 1'b1;
                    state_next  = (remain_reg == CNT_W'(1)) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            dropped_reg   <= '0;
            rd_ptr_reg    <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            dropped_reg   <= dropped_next;
            rd_ptr_reg    <= rd_ptr_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        kind_reg          <= kind_next;
        entry_count_reg   <= entry_count_next;
        dropped_count_reg <= dropped_count_next;
        out_ev_reg        <= out_ev_next;
        last_reg          <= last_next;
    end

    // Ring write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[head_reg] <= q_item.ev;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign entry_count   = entry_count_reg;
    assign dropped_count = dropped_count_reg;
    assign out_time_ms   = out_ev_reg.time_ms;
    assign out_source    = out_ev_reg.source;
    assign out_code      = out_ev_reg.code;
    assign out_a         = out_ev_reg.a;
    assign out_b         = out_ev_reg.b;
    assign last          = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/overwriting_event_trace_buffer_unit.sv -----
// Top level of the overwriting event trace buffer: front end, queue and back end.
// Records: one beat per cycle sustained while no dump is in progress; the back end then
//   writes one entry per cycle through the single ring write port, taking each beat from the queue.
// Dump: the header is loaded into the output register as the back end takes the command,
//   then each stored entry passes a registered ring read (S_READ), then an output load (S_EMIT).
// Reset: rst_n clears head, fill, dropped, queue and sequencer at once; ring
//   contents are not cleared, since a dump reads only entries written since.
`default_nettype none

module overwriting_event_trace_buffer_unit #(
    parameter int DEPTH        = 32,
    parameter int SOURCE_COUNT = 6
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              command,
    input  wire logic [otb_pkg::TIME_W-1:0]        time_ms,
    input  wire logic [otb_pkg::SRC_W-1:0]         source,
    input  wire logic [otb_pkg::CODE_W-1:0]        event_code,
    input  wire logic signed [otb_pkg::ARG_W-1:0]  value_a,
    input  wire logic signed [otb_pkg::ARG_W-1:0]  value_b,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   kind,
    output logic [otb_pkg::COUNT_W-1:0]            entry_count,
    output logic [otb_pkg::DROP_W-1:0]             dropped_count,
    output logic [otb_pkg::TIME_W-1:0]             out_time_ms,
    output logic [otb_pkg::SRC_W-1:0]              out_source,
    output logic [otb_pkg::CODE_W-1:0]             out_code,
    output logic signed [otb_pkg::ARG_W-1:0]       out_a,
    output logic signed [otb_pkg::ARG_W-1:0]       out_b,
    output logic                                   last
);
    import otb_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    item_t push_item;
    item_t head_item;

    otb_front #(
        .SOURCE_COUNT (SOURCE_COUNT)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .time_ms    (time_ms),
        .source     (source),
        .event_code (event_code),
        .value_a    (value_a),
        .value_b    (value_b),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    otb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    otb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_item        (head_item),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .entry_count   (entry_count),
        .dropped_count (dropped_count),
        .out_time_ms   (out_time_ms),
        .out_source    (out_source),
        .out_code      (out_code),
        .out_a         (out_a),
        .out_b         (out_b),
        .last          (last)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/otb_checker.sv -----
// Port-level checker for the trace buffer, bound to the top level.
`default_nettype none

module otb_checker #(
    parameter int DEPTH        = 32,
    parameter int SOURCE_COUNT = 6
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic                              kind,
    input wire logic [otb_pkg::COUNT_W-1:0]       entry_count,
    input wire logic [otb_pkg::DROP_W-1:0]        dropped_count,
    input wire logic [otb_pkg::SRC_W-1:0]         out_source,
    input wire logic                              last
);
    import otb_pkg::*;

    // Stalled beat stays valid
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    // Stalled beat keeps its kind and last flag
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(kind) && $stable(last))
        else $error("output beat changed while stalled");

    // Header count fits the ring and ends the dump exactly when empty
    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_HEADER) |->
            (entry_count <= COUNT_W'(DEPTH)) && (last == (entry_count == '0)))
        else $error("header count inconsistent");

    // Entry beats carry no counts and only accepted sources
    a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ENTRY) |->
            (entry_count == '0) && (dropped_count == '0)
            && ({1'b0, out_source} < (SRC_W + 1)'(SOURCE_COUNT)))
        else $error("entry beat fields inconsistent");

endmodule

bind overwriting_event_trace_buffer_unit otb_checker #(
    .DEPTH        (DEPTH),
    .SOURCE_COUNT (SOURCE_COUNT)
) u_otb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .entry_count   (entry_count),
    .dropped_count (dropped_count),
    .out_source    (out_source),
    .last          (last)
);

`default_nettype wire

// ----- bench/tb_overwriting_event_trace_buffer_unit.sv -----
// Self-checking testbench for the overwriting event trace buffer unit.
module tb_overwriting_event_trace_buffer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import otb_pkg::*;

    localparam int DEPTH          = 32;
    localparam int SOURCE_COUNT   = 6;
    localparam int RANDOM_BEATS   = 100;
    localparam int QUIET_TAIL     = 20;
    localparam int WATCHDOG_LIMIT = 1000;

    // One command beat on the input channel
    typedef struct {
        logic                    cmd;
        logic [TIME_W-1:0]       stamp;
        logic [SRC_W-1:0]        src;
        logic [CODE_W-1:0]       code;
        logic signed [ARG_W-1:0] a;
        logic signed [ARG_W-1:0] b;
    } command_beat_t;

    // One dump beat on the output channel
    typedef struct {
        logic                 kind;
        logic [COUNT_W-1:0]   cnt;
        logic [DROP_W-1:0]    drop;
        entry_t               ev;
        logic                 last;
    } dump_beat_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    command = CMD_RECORD;
    logic [TIME_W-1:0]       time_ms = '0;
    logic [SRC_W-1:0]        source = '0;
    logic [CODE_W-1:0]       event_code = '0;
    logic signed [ARG_W-1:0] value_a = '0;
    logic signed [ARG_W-1:0] value_b = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    kind;
    logic [COUNT_W-1:0]      entry_count;
    logic [DROP_W-1:0]       dropped_count;
    logic [TIME_W-1:0]       out_time_ms;
    logic [SRC_W-1:0]        out_source;
    logic [CODE_W-1:0]       out_code;
    logic signed [ARG_W-1:0] out_a;
    logic signed [ARG_W-1:0] out_b;
    logic                    last;

    // Commands waiting to be driven, and dump beats waiting to arrive
    command_beat_t pending_commands[$];
    dump_beat_t    dump_expected[$];

    // Predicted ring contents and pointers
    entry_t        ring_image[DEPTH];
    int            ring_head = 0;
    int            ring_fill = 0;
    logic [DROP_W-1:0] ring_dropped = '0;

    int n_offered = 0;
    int n_in_acc = 0;
    int n_results = 0;
    int n_records = 0;
    int n_ignored = 0;
    int n_dumps = 0;
    int n_overwrites = 0;
    int errors = 0;
    int idle_cycles = 0;
    int in_gap_left = 0;
    int out_hold_left = 0;
    int command_total;

    overwriting_event_trace_buffer_unit #(
        .DEPTH        (DEPTH),
        .SOURCE_COUNT (SOURCE_COUNT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .time_ms       (time_ms),
        .source        (source),
        .event_code    (event_code),
        .value_a       (value_a),
        .value_b       (value_b),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .entry_count   (entry_count),
        .dropped_count (dropped_count),
        .out_time_ms   (out_time_ms),
        .out_source    (out_source),
        .out_code      (out_code),
        .out_a         (out_a),
        .out_b         (out_b),
        .last          (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the predicted ring by one accepted command; queue any dump beats
    function automatic void track_command(input command_beat_t cb);
        dump_beat_t r;
        int         idx;
        if (cb.cmd == CMD_RECORD)
        begin
            if (cb.src >= SOURCE_COUNT)
            begin
                n_ignored++;
                return;
            end
            n_records++;
            ring_image[ring_head].time_ms = cb.stamp;
            ring_image[ring_head].source  = cb.src;
            ring_image[ring_head].code    = cb.code;
            ring_image[ring_head].a       = cb.a;
            ring_image[ring_head].b       = cb.b;
            ring_head = (ring_head + 1) % DEPTH;
            if (ring_fill < DEPTH)
                ring_fill++;
            else
            begin
                n_overwrites++;
                if (ring_dropped != '1)
                    ring_dropped++;
            end
        end
        else
        begin
            n_dumps++;
            r = '{kind: KIND_HEADER, cnt: COUNT_W'(ring_fill), drop: ring_dropped, ev: '0,
                  last: (ring_fill == 0)};
            dump_expected.push_back(r);
            for (int i = 0; i < ring_fill; i++)
            begin
                idx = (ring_head + DEPTH - ring_fill + i) % DEPTH;
                r = '{kind: KIND_ENTRY, cnt: '0, drop: '0, ev: ring_image[idx],
                      last: (i == ring_fill - 1)};
                dump_expected.push_back(r);
            end
            ring_head = 0;
            ring_fill = 0;
            ring_dropped = '0;
        end
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            errors++;
        end
    endtask

    function automatic void add_record(input logic [TIME_W-1:0] stamp,
                                       input logic [SRC_W-1:0] src,
                                       input logic [CODE_W-1:0] code,
                                       input logic signed [ARG_W-1:0] a,
                                       input logic signed [ARG_W-1:0] b);
        command_beat_t cb;
        cb = '{cmd: CMD_RECORD, stamp: stamp, src: src, code: code, a: a, b: b};
        pending_commands.push_back(cb);
    endfunction

    function automatic void add_dump();
        command_beat_t cb;
        cb.cmd   = CMD_DUMP;
        cb.stamp = TIME_W'($urandom);
        cb.src   = SRC_W'($urandom);
        cb.code  = CODE_W'($urandom);
        cb.a     = ARG_W'($urandom);
        cb.b     = ARG_W'($urandom);
        pending_commands.push_back(cb);
    endfunction

    // Random record; a rejected source when asked for noise
    function automatic void add_random_record(input bit noise);
        logic [SRC_W-1:0] src;
        src = noise ? SRC_W'($urandom_range(SOURCE_COUNT, 15))
                    : SRC_W'($urandom_range(0, SOURCE_COUNT - 1));
        add_record(TIME_W'($urandom), src, CODE_W'($urandom), ARG_W'($urandom),
                   ARG_W'($urandom));
    endfunction

    // Drive command beats and output stall at the falling edge
    always @(negedge clk)
    begin
        command_beat_t nxt;
        bit            quiet;
        if (rst_n)
        begin
            quiet = (pending_commands.size() < QUIET_TAIL);

            // stall the output in random bursts
            if (out_hold_left != 0)
            begin
                out_stall <= 1'b1;
                out_hold_left--;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                out_hold_left = $urandom_range(0, 4);
            end
            else
                out_stall <= 1'b0;

            // hold a beat until taken, else idle or present the next one
            if (in_valid && n_in_acc != n_offered)
            begin
            end
            else if (in_gap_left != 0)
            begin
                in_valid <= 1'b0;
                in_gap_left--;
            end
            else if (pending_commands.size() == 0)
                in_valid <= 1'b0;
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                in_gap_left = $urandom_range(0, 4);
            end
            else
            begin
                nxt = pending_commands.pop_front();
                command    <= nxt.cmd;
                time_ms    <= nxt.stamp;
                source     <= nxt.src;
                event_code <= nxt.code;
                value_a    <= nxt.a;
                value_b    <= nxt.b;
                in_valid   <= 1'b1;
                n_offered++;
            end
        end
    end

    // Sample both channels at the rising edge; predict, check and watch for hangs
    always @(posedge clk)
    begin
        command_beat_t cb;
        dump_beat_t    want;
        bit            took;
        if (rst_n)
        begin
            took = 1'b0;
            if (in_valid && !in_stall)
            begin
                took = 1'b1;
                n_in_acc++;
                cb = '{cmd: command, stamp: time_ms, src: source, code: event_code,
                       a: value_a, b: value_b};
                track_command(cb);
            end
            if (out_valid && !out_stall)
            begin
                took = 1'b1;
                n_results++;
                if (dump_expected.size() == 0)
                begin
                    $error("unexpected output beat: kind %0b last %0b", kind, last);
                    errors++;
                end
                else
                begin
                    want = dump_expected.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("entry_count", want.cnt, entry_count);
                    check_field("dropped_count", want.drop, dropped_count);
                    check_field("out_time_ms", want.ev.time_ms, out_time_ms);
                    check_field("out_source", want.ev.source, out_source);
                    check_field("out_code", want.ev.code, out_code);
                    check_field("out_a", want.ev.a, out_a);
                    check_field("out_b", want.ev.b, out_b);
                    check_field("last", want.last, last);
                end
            end
            idle_cycles = took ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d beats still expected",
                         idle_cycles, dump_expected.size());
                $display("tb_overwriting_event_trace_buffer_unit failed");
                $finish;
            end
        end
    end

    initial
    begin
        int counted;
        int seq_len;
        bit first_seq;

        // empty dump, then field extremes and rejected sources
        add_dump();
        add_record(16'h0000, 4'd0, 8'h00, -16'sd32768, 16'sd32767);
        add_record(16'hFFFF, SRC_W'(SOURCE_COUNT - 1), 8'hFF, 16'sd32767, -16'sd32768);
        add_record(16'hAAAA, SRC_W'(SOURCE_COUNT), 8'h55, 16'sh5555, -16'sd21846);
        add_record(16'h5555, 4'd15, 8'hAA, -16'sd1, 16'sd0);
        add_record(16'h5555, 4'd3, 8'h55, 16'sh5555, -16'sd21846);
        add_dump();
        add_dump();
        add_record(16'h1234, 4'd1, 8'h80, -16'sd2, 16'sd1);
        add_dump();

        // bursts of records ending in a dump; the first one has DEPTH + 8 records and can wrap the ring
        counted = 0;
        first_seq = 1'b1;
        while (counted < RANDOM_BEATS)
        begin
            if (first_seq)
                seq_len = DEPTH + 8;
            else if ($urandom_range(0, 7) == 0)
                seq_len = $urandom_range(DEPTH, DEPTH + 12);
            else
                seq_len = $urandom_range(0, 8);
            first_seq = 1'b0;
            for (int i = 0; i < seq_len; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                    add_random_record(1'b1);
                else
                begin
                    add_random_record(1'b0);
                    counted++;
                end
            end
            add_dump();
            counted++;
        end
        command_total = pending_commands.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: all commands taken, all dump beats seen, then a short tail
        while (n_in_acc != command_total)
            @(posedge clk);
        while (dump_expected.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);

        $display("covered %0d records (%0d more with rejected source), %0d dumps, %0d overwrites",
                 n_records, n_ignored, n_dumps, n_overwrites);
        $display("checked %0d output beats, %0d mismatches", n_results, errors);
        if (errors == 0)
            $display("tb_overwriting_event_trace_buffer_unit passed");
        else
            $display("tb_overwriting_event_trace_buffer_unit failed");
        $finish;
    end

endmodule
